/* sv/mcstb_pkg.sv */
// Shared types and constants for the multi-channel soft timer bank.
// Used by mcstb_ctrl, mcstb_dp and multi_channel_soft_timer_bank.
package mcstb_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TICK_W   = 32;
	localparam int CHOUT_W  = 6;

	localparam logic [2:0] FN_ALLOC   = 3'd0;
	localparam logic [2:0] FN_START   = 3'd1;
	localparam logic [2:0] FN_STOP    = 3'd2;
	localparam logic [2:0] FN_FREE    = 3'd3;
	localparam logic [2:0] FN_SETIV   = 3'd4;
	localparam logic [2:0] FN_QUERY   = 3'd5;
	localparam logic [2:0] FN_PROCESS = 3'd6;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [TICK_W-1:0] tick_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sweep_init;
		logic sweep_step;
		logic out_load;
		logic out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_proc;
		logic hit;
		logic sweep_end;
	} dp_status_t;

endpackage

/* sv/mcstb_ctrl.sv */
// Controller state machine for the timer bank: handshakes, sweep sequencing
// and output register valid. Depends on mcstb_pkg.
module mcstb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mcstb_pkg::dp_status_t status,
	output mcstb_pkg::dp_cmd_t    cmd
);
	import mcstb_pkg::*;

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   stall;

	assign slot_free = !out_valid_q || out_ready;
	assign stall     = status.hit && pend_q && !slot_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.in_is_proc) begin
						cmd.sweep_init = 1'b1;
						pend_d         = 1'b0;
						state_d        = ST_SWEEP;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_SWEEP: begin
				if (!stall) begin
					cmd.sweep_step = 1'b1;
					if (status.hit) begin
						pend_d = 1'b1;
						if (pend_q)
							cmd.out_load = 1'b1;
					end
					if (status.sweep_end)
						state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* sv/mcstb_dp.sv */
// Datapath for the timer bank: channel state, elapsed/expiry unit, sweep
// counter, result staging and output register. Depends on mcstb_pkg.
module mcstb_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           func,
	input  logic [7:0]           handle,
	input  logic [31:0]          interval,
	input  logic                 periodic,
	input  logic                 notify,
	input  logic [31:0]          now,
	input  mcstb_pkg::dp_cmd_t    cmd,
	output mcstb_pkg::dp_status_t status,
	output logic                 ok,
	output logic [5:0]           channel,
	output logic [31:0]          elapsed,
	output logic [31:0]          remaining,
	output logic                 expired,
	output logic                 fired,
	output logic                 last
);
	import mcstb_pkg::*;

	// item registers
	logic [2:0] func_q;
	logic [7:0] handle_q;
	tick_t      interval_q;
	logic       periodic_q;
	logic       notify_q;
	tick_t      now_q;

	// channel state
	logic [CHANNELS-1:0] in_use_q;
	logic [CHANNELS-1:0] active_q;
	logic [CHANNELS-1:0] repeat_q;
	logic [CHANNELS-1:0] notify_en_q;
	tick_t               period_q [CHANNELS];
	tick_t               start_q  [CHANNELS];
	tick_t               frozen_q [CHANNELS];

	chan_t cnt_q;

	// result staging
	logic                r_ok_q;
	logic [CHOUT_W-1:0]  r_ch_q;
	logic                r_fired_q;
	logic                r_query_q;
	tick_t               r_el_q;
	tick_t               r_per_q;

	chan_t hidx, idx, fidx;
	logic  found, hv, el_due, due_live;
	tick_t el_c;
	logic  wr_alloc, wr_start, wr_stop, wr_free, wr_setiv, wr_exp;
	logic  r_ex;

	assign hidx = handle_q[CH_W-1:0];
	assign idx  = cmd.exec ? hidx : cnt_q;
	assign hv   = (handle_q < 8'(CHANNELS)) && in_use_q[hidx];

	assign el_c     = active_q[idx] ? (now_q - start_q[idx]) : frozen_q[idx];
	assign el_due   = el_c >= period_q[idx];
	assign due_live = in_use_q[idx] && active_q[idx] && el_due;

	assign status.in_is_proc = (func == FN_PROCESS);
	assign status.hit        = due_live && notify_en_q[idx];
	assign status.sweep_end  = (cnt_q == CH_W'(CHANNELS - 1));

	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				found = 1'b1;
				fidx  = CH_W'(i);
			end
		end
	end

	always_comb begin
		wr_alloc = 1'b0;
		wr_start = 1'b0;
		wr_stop  = 1'b0;
		wr_free  = 1'b0;
		wr_setiv = 1'b0;
		unique case (func_q)
			FN_ALLOC: wr_alloc = cmd.exec && found;
			FN_START: wr_start = cmd.exec && hv;
			FN_STOP:  wr_stop  = cmd.exec && hv;
			FN_FREE:  wr_free  = cmd.exec && hv;
			FN_SETIV: wr_setiv = cmd.exec && hv;
			default: ;
		endcase
	end

	assign wr_exp = cmd.sweep_step && due_live;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			handle_q   <= handle;
			interval_q <= interval;
			periodic_q <= periodic;
			notify_q   <= notify;
			now_q      <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			active_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_alloc) begin
				in_use_q[fidx] <= 1'b1;
				active_q[fidx] <= 1'b0;
			end
			if (wr_start)
				active_q[idx] <= 1'b1;
			if (wr_stop)
				active_q[idx] <= 1'b0;
			if (wr_free) begin
				in_use_q[idx] <= 1'b0;
				active_q[idx] <= 1'b0;
			end
			if (wr_exp && !repeat_q[idx])
				active_q[idx] <= 1'b0;
			if (cmd.sweep_init)
				cnt_q <= '0;
			else if (cmd.sweep_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_alloc) begin
			repeat_q[fidx]    <= periodic_q;
			notify_en_q[fidx] <= notify_q;
			period_q[fidx]    <= interval_q;
			start_q[fidx]     <= '0;
			frozen_q[fidx]    <= '0;
		end
		if (wr_start) begin
			start_q[idx]  <= now_q;
			frozen_q[idx] <= '0;
		end
		if (wr_stop && active_q[idx])
			frozen_q[idx] <= el_c;
		if (wr_setiv)
			period_q[idx] <= interval_q;
		if (wr_exp) begin
			if (repeat_q[idx]) begin
				start_q[idx]  <= start_q[idx] + period_q[idx];
				frozen_q[idx] <= '0;
			end else begin
				frozen_q[idx] <= period_q[idx];
			end
		end
	end

	// staging: process starts with the no-expiry result, each notifying hit
	// replaces it
	always_ff @(posedge clk) begin
		if (cmd.sweep_init) begin
			r_ok_q    <= 1'b1;
			r_ch_q    <= '0;
			r_fired_q <= 1'b0;
			r_query_q <= 1'b0;
		end else if (cmd.sweep_step && status.hit) begin
			r_ch_q    <= CHOUT_W'(cnt_q);
			r_fired_q <= 1'b1;
		end else if (cmd.exec) begin
			r_el_q    <= el_c;
			r_per_q   <= period_q[idx];
			r_fired_q <= 1'b0;
			r_query_q <= 1'b0;
			unique case (func_q) inside
				FN_ALLOC: begin
					r_ok_q <= found;
					r_ch_q <= found ? CHOUT_W'(fidx) : '0;
				end
				FN_START, FN_STOP, FN_FREE, FN_SETIV, FN_QUERY: begin
					r_ok_q    <= hv;
					r_ch_q    <= hv ? CHOUT_W'(hidx) : '0;
					r_query_q <= hv && (func_q == FN_QUERY);
				end
				default: begin
					r_ok_q <= 1'b0;
					r_ch_q <= '0;
				end
			endcase
		end
	end

	assign r_ex = r_el_q >= r_per_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ok        <= r_ok_q;
			channel   <= r_ch_q;
			elapsed   <= r_query_q ? r_el_q : '0;
			remaining <= (r_query_q && !r_ex) ? (r_per_q - r_el_q) : '0;
			expired   <= r_query_q && r_ex;
			fired     <= r_fired_q;
			last      <= cmd.out_last;
		end
	end

endmodule

/* sv/multi_channel_soft_timer_bank.sv */
// Multi-channel soft timer bank, top level. Instantiates mcstb_ctrl and mcstb_dp.
// Alloc/start/stop/free/set/query results are staged in ST_EXEC and load in ST_RESP
// once the output slot is free; no new item is taken until then. Process walks one
// channel per cycle via the shared elapsed/compare unit unless the output stalls.
// Reset (arst_n low, async): all channels free and stopped, no result pending.
module multi_channel_soft_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  handle,
	input  logic [31:0] interval,
	input  logic        periodic,
	input  logic        notify,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [5:0]  channel,
	output logic [31:0] elapsed,
	output logic [31:0] remaining,
	output logic        expired,
	output logic        fired,
	output logic        last
);
	import mcstb_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mcstb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mcstb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.handle    (handle),
		.interval  (interval),
		.periodic  (periodic),
		.notify    (notify),
		.now       (now),
		.cmd       (cmd),
		.status    (status),
		.ok        (ok),
		.channel   (channel),
		.elapsed   (elapsed),
		.remaining (remaining),
		.expired   (expired),
		.fired     (fired),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in progress");

	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> ok && !expired && elapsed == '0 && remaining == '0)
		else $error("fire transaction carries query fields");

	a_expired_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> remaining == '0 && ok)
		else $error("expired query with nonzero remaining");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> channel == '0 && last && !fired)
		else $error("failed transaction not cleared");
`endif

endmodule
